// ===== hdl/biquad_cascade_equalizer_defines.svh =====
// Assertion macros shared by the checker.
`ifndef BIQUAD_CASCADE_EQUALIZER_DEFINES_SVH
`define BIQUAD_CASCADE_EQUALIZER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BQE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/bqe_pkg.sv =====
`timescale 1ns / 1ps
package bqe_pkg;
  localparam int MAX_BANDS_DEF = 8;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int NUM_COEF = 5;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_BAND, ST_RD, ST_MUL, ST_ACC, ST_SAT, ST_WB, ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic clr_acc;    // zero accumulator, start band
    logic rd;         // issue reads for current tap
    logic mul;        // register product
    logic acc;        // accumulate product
    logic sat;        // round and saturate band output
    logic wb;         // write back history
    logic clr_wr;     // write zeros at clear address
    logic clr_coef;   // write a zero coefficient at clear address
    logic out_load;   // load output register
    logic bypass;     // output passes sample unchanged
  } ctl_t;
endpackage

// ===== hdl/bqe_datapath.sv =====
`timescale 1ns / 1ps
module bqe_datapath #(
  parameter int MAX_BANDS = bqe_pkg::MAX_BANDS_DEF,
  parameter int MAX_CHANNELS = bqe_pkg::MAX_CHANNELS_DEF,
  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int HD = MAX_CHANNELS * MAX_BANDS,
  localparam int HW = (HD > 1) ? $clog2(HD) : 1,
  localparam int KD = MAX_BANDS * 5,
  localparam int KW = $clog2(KD),
  localparam int CLD = (HD > KD) ? HD : KD,
  localparam int CLW = $clog2(CLD)
) (
  input  logic clk,
  input  bqe_pkg::ctl_t ctl,
  input  logic [2:0] tap,
  input  logic [BW-1:0] band_idx,
  input  logic [CLW-1:0] clr_addr,
  input  logic coef_we,
  input  logic [2:0] band,
  input  logic [2:0] coef_select,
  input  logic signed [31:0] coef_value,
  input  logic [2:0] channel,
  input  logic signed [23:0] sample_in,
  input  logic end_of_block,
  output logic signed [23:0] sample_out,
  output logic [2:0] channel_out,
  output logic end_of_block_out
);
  import bqe_pkg::*;

  logic signed [31:0] coef_mem [KD];
  logic signed [31:0] x1_mem [HD];
  logic signed [31:0] x2_mem [HD];
  logic signed [31:0] y1_mem [HD];
  logic signed [31:0] y2_mem [HD];

  logic signed [31:0] x;
  logic signed [23:0] smp;
  logic [2:0] ch;
  logic eob;
  logic signed [31:0] c_rd, h_rd, x1_rd, y1_rd;
  logic signed [63:0] prod;
  // Five floored products reach 45 bits, so the sum is kept at 48.
  logic signed [47:0] acc;
  logic [HW-1:0] haddr;
  logic [HW-1:0] clr_haddr;
  logic [KW-1:0] kaddr, waddr, clr_kaddr;
  logic signed [63:0] mul_full;
  logic signed [47:0] rnd;
  logic signed [31:0] y;

  assign haddr = HW'(ch) * HW'(MAX_BANDS) + HW'(band_idx);
  assign kaddr = KW'(band_idx) * KW'(5) + KW'(tap);
  assign waddr = KW'(band) * KW'(5) + KW'(coef_select);
  assign clr_haddr = clr_addr[HW-1:0];
  assign clr_kaddr = clr_addr[KW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.clr_coef) begin
      coef_mem[clr_kaddr] <= '0;
    end else if (coef_we) begin
      coef_mem[waddr] <= coef_value;
    end
    if (ctl.rd) begin
      c_rd <= coef_mem[kaddr];
    end
  end

  // Tap 0 uses x; taps 1..4 read the history word of that tap.
  always_ff @(posedge clk) begin
    if (ctl.clr_wr) begin
      x1_mem[clr_haddr] <= '0;
      x2_mem[clr_haddr] <= '0;
      y1_mem[clr_haddr] <= '0;
      y2_mem[clr_haddr] <= '0;
    end else if (ctl.wb) begin
      x2_mem[haddr] <= x1_rd;
      x1_mem[haddr] <= x;
      y2_mem[haddr] <= y1_rd;
      y1_mem[haddr] <= y;
    end
    if (ctl.rd) begin
      case (tap)
        SEL_B1: h_rd <= x1_mem[haddr];
        SEL_B2: h_rd <= x2_mem[haddr];
        SEL_A1: h_rd <= y1_mem[haddr];
        SEL_A2: h_rd <= y2_mem[haddr];
        default: h_rd <= x;
      endcase
    end
  end

  assign mul_full = 64'(c_rd) * 64'(h_rd);
  assign rnd = (acc + 48'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      smp <= sample_in;
      ch <= channel;
      eob <= end_of_block;
      x <= {{7{sample_in[23]}}, sample_in, 1'b0};
    end
    if (ctl.mul) begin
      prod <= mul_full >>> 20;
      if (tap == SEL_B1) x1_rd <= h_rd;
      if (tap == SEL_A1) y1_rd <= h_rd;
    end
    if (ctl.clr_acc) begin
      acc <= '0;
    end else if (ctl.acc) begin
      if (tap == SEL_A1 || tap == SEL_A2) acc <= acc - 48'(prod);
      else acc <= acc + 48'(prod);
    end
    if (ctl.sat) begin
      if (rnd > 48'sd2147483647) y <= 32'sh7fffffff;
      else if (rnd < -48'sd2147483648) y <= 32'sh80000000;
      else y <= rnd[31:0];
    end
    if (ctl.wb) begin
      x <= y;
    end
    if (ctl.out_load) begin
      channel_out <= ch;
      end_of_block_out <= eob;
      if (ctl.bypass) sample_out <= smp;
      else if (x >= 32'sd16777216) sample_out <= 24'sh7fffff;
      else if (x <= -32'sd16777216) sample_out <= 24'sh800000;
      else sample_out <= x[24:1];
    end
  end
endmodule

// ===== hdl/bqe_controller.sv =====
`timescale 1ns / 1ps
module bqe_controller #(
  parameter int MAX_BANDS = bqe_pkg::MAX_BANDS_DEF,
  parameter int MAX_CHANNELS = bqe_pkg::MAX_CHANNELS_DEF,
  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  localparam int HD = MAX_CHANNELS * MAX_BANDS,
  localparam int KD = MAX_BANDS * 5,
  localparam int CLD = (HD > KD) ? HD : KD,
  localparam int CLW = $clog2(CLD)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] operation,
  input  logic [2:0] channel,
  input  logic [2:0] band,
  input  logic [2:0] coef_select,
  input  logic [3:0] active_bands,
  output logic out_valid,
  input  logic out_stall,
  output bqe_pkg::ctl_t ctl,
  output logic coef_we,
  output logic [2:0] tap,
  output logic [BW-1:0] band_idx,
  output logic [CLW-1:0] clr_addr
);
  import bqe_pkg::*;

  state_t state, state_next;
  logic [2:0] tap_next;
  logic [BW-1:0] band_idx_next;
  logic [CLW-1:0] clr_addr_next;
  logic [5:0] nb, nb_next;
  logic out_valid_next;
  logic accept;
  logic [5:0] ab_lim;

  assign ab_lim = (32'(active_bands) > MAX_BANDS) ? 6'(MAX_BANDS) : 6'(active_bands);
  assign accept = in_valid && !in_stall;
  assign coef_we = accept && operation == OP_COEF &&
                   32'(band) < MAX_BANDS && coef_select <= SEL_A2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      out_valid <= 1'b0;
      tap <= '0;
      band_idx <= '0;
      clr_addr <= '0;
      nb <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      tap <= tap_next;
      band_idx <= band_idx_next;
      clr_addr <= clr_addr_next;
      nb <= nb_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next = tap;
    band_idx_next = band_idx;
    clr_addr_next = clr_addr;
    nb_next = nb;
    out_valid_next = out_valid && out_stall;
    ctl = '0;
    in_stall = 1'b1;
    case (state)
      ST_INIT: begin
        // Zero history and coefficients once after reset.
        ctl.clr_wr = (32'(clr_addr) < HD);
        ctl.clr_coef = (32'(clr_addr) < KD);
        clr_addr_next = clr_addr + 1'b1;
        if (32'(clr_addr) == CLD - 1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = out_valid;
        if (accept) begin
          ctl.load = 1'b1;
          case (operation)
            OP_FILTER: begin
              band_idx_next = '0;
              if (ab_lim == 6'd0 || 32'(channel) >= MAX_CHANNELS) begin
                nb_next = '0;
                state_next = ST_OUT;
              end else begin
                nb_next = ab_lim;
                state_next = ST_BAND;
              end
            end
            OP_CLEAR: begin
              clr_addr_next = '0;
              state_next = ST_CLEAR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (32'(clr_addr) == HD - 1) state_next = ST_IDLE;
      end
      ST_BAND: begin
        ctl.clr_acc = 1'b1;
        tap_next = SEL_B0;
        state_next = ST_RD;
      end
      ST_RD: begin
        ctl.rd = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc = 1'b1;
        if (tap == SEL_A2) begin
          state_next = ST_SAT;
        end else begin
          tap_next = tap + 3'd1;
          state_next = ST_RD;
        end
      end
      ST_SAT: begin
        ctl.sat = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        ctl.wb = 1'b1;
        if (6'(band_idx) + 6'd1 >= nb) begin
          state_next = ST_OUT;
        end else begin
          band_idx_next = band_idx + 1'b1;
          state_next = ST_BAND;
        end
      end
      ST_OUT: begin
        if (!out_valid) begin
          ctl.out_load = 1'b1;
          ctl.bypass = (nb == 6'd0);
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/biquad_cascade_equalizer.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake                | Payload
// input     | in_valid / in_stall      | operation .. coef_value
// output    | out_valid / out_stall    | sample_out, channel_out, end_of_block_out
// config    | cfg_valid / cfg_ready    | cfg_data (active_bands)
//
// A filter item runs its bands in turn: every band has a start step, five
// multiply-accumulates on one shared 32x32 multiplier, each a read, a
// multiply and an accumulate step, then a step to round and one to write
// back the history memories. A clear-history item sweeps the history
// memories one entry per cycle. Reset is synchronous and clears control
// state and active_bands; afterwards in_stall stays high while one sweep
// zeroes the history and coefficient memories. The output register holds
// a result while out_stall is high, and the next item is accepted only
// once it is taken.
module biquad_cascade_equalizer #(
  parameter int MAX_BANDS = bqe_pkg::MAX_BANDS_DEF,
  parameter int MAX_CHANNELS = bqe_pkg::MAX_CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] operation,
  input  logic [2:0] channel,
  input  logic signed [23:0] sample_in,
  input  logic end_of_block,
  input  logic [2:0] band,
  input  logic [2:0] coef_select,
  input  logic signed [31:0] coef_value,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [23:0] sample_out,
  output logic [2:0] channel_out,
  output logic end_of_block_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_data
);
  import bqe_pkg::*;

  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int HD = MAX_CHANNELS * MAX_BANDS;
  localparam int KD = MAX_BANDS * 5;
  localparam int CLD = (HD > KD) ? HD : KD;
  localparam int CLW = $clog2(CLD);

  logic [3:0] active_bands;
  ctl_t ctl;
  logic coef_we;
  logic [2:0] tap;
  logic [BW-1:0] band_idx;
  logic [CLW-1:0] clr_addr;

  // The band count register is always writable.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bands <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_bands <= cfg_data;
    end
  end

  bqe_controller #(.MAX_BANDS(MAX_BANDS), .MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .operation, .channel, .band, .coef_select,
    .active_bands, .out_valid, .out_stall, .ctl, .coef_we, .tap, .band_idx,
    .clr_addr
  );

  bqe_datapath #(.MAX_BANDS(MAX_BANDS), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk, .ctl, .tap, .band_idx, .clr_addr, .coef_we, .band, .coef_select,
    .coef_value, .channel, .sample_in, .end_of_block, .sample_out,
    .channel_out, .end_of_block_out
  );
endmodule

// ===== hdl/bqe_checker.sv =====
`timescale 1ns / 1ps
`include "biquad_cascade_equalizer_defines.svh"
module bqe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [23:0] sample_out
);
  `BQE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "result dropped under stall")
  `BQE_ASSERT_IMPL(a_busy_out, out_valid, in_stall, "item accepted while result waits")
  `BQE_ASSERT_NEXT(a_no_instant, in_valid && !in_stall, !out_valid, "result in cycle after accept")
endmodule

bind biquad_cascade_equalizer bqe_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sample_out
);
